@@ rtl/lldp_transmit_scheduler_unit_macros.svh @@
// Assertion macros for the LLDP transmit scheduler.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef LLDP_TRANSMIT_SCHEDULER_UNIT_MACROS_SVH
`define LLDP_TRANSMIT_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LTS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lts_pkg.sv @@
// Shared types and constants of the LLDP transmit scheduler.
// No dependencies; used by the channel interfaces and the top level.
package lts_pkg;

    // Field widths
    localparam int INTERVAL_W = 12;
    localparam int HOLD_W     = 7;
    localparam int COUNT_W    = 4;
    localparam int TTL_W      = 16;
    localparam int PROD_W     = INTERVAL_W + HOLD_W + 1;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MSG_TX_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_TX_HOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_FAST_TX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TX_FAST_INIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TX_CREDIT_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REINIT_DELAY    = 3'd5;

    // Register reset values
    localparam logic [INTERVAL_W-1:0] RST_MSG_TX_INTERVAL = 12'd30;
    localparam logic [HOLD_W-1:0]     RST_MSG_TX_HOLD     = 7'd4;
    localparam logic [INTERVAL_W-1:0] RST_MSG_FAST_TX     = 12'd1;
    localparam logic [COUNT_W-1:0]    RST_TX_FAST_INIT    = 4'd4;
    localparam logic [COUNT_W-1:0]    RST_TX_CREDIT_MAX   = 4'd5;
    localparam logic [COUNT_W-1:0]    RST_REINIT_DELAY    = 4'd2;

    // Saturation limit of the advertised TTL
    localparam logic [TTL_W-1:0] TTL_MAX = 16'hFFFF;

    // Admin status codes
    localparam logic [1:0] ADMIN_DISABLED = 2'd0;
    localparam logic [1:0] ADMIN_TX_ONLY  = 2'd1;
    localparam logic [1:0] ADMIN_RX_ONLY  = 2'd2;
    localparam logic [1:0] ADMIN_RX_TX    = 2'd3;

    // Frame kinds
    localparam logic [1:0] FRAME_NONE     = 2'd0;
    localparam logic [1:0] FRAME_INFO     = 2'd1;
    localparam logic [1:0] FRAME_SHUTDOWN = 2'd2;

    // Phase codes as they appear in a result
    localparam logic [1:0] TX_CODE_INIT  = 2'd0;
    localparam logic [1:0] TX_CODE_IDLE  = 2'd1;
    localparam logic [1:0] TX_CODE_SHUT  = 2'd2;
    localparam logic       TMR_CODE_INIT = 1'b0;

    typedef struct packed {
        logic       mode;
        logic       mac_operational;
        logic [1:0] admin_status;
        logic       new_neighbor;
        logic       local_change;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic [TTL_W-1:0]   frame_ttl;
        logic [1:0]         tx_phase;
        logic               timer_phase;
        logic [COUNT_W-1:0] credit_left;
    } rsp_item_t;

endpackage

@@ rtl/lts_stream_if.sv @@
// Valid/ready channel interfaces for event requests and results.
// Depends on lts_pkg for the payload structs.
interface lts_req_if import lts_pkg::*; ();
    logic      valid;
    logic      ready;
    req_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lts_rsp_if import lts_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/lldp_transmit_scheduler_unit.sv @@
// LLDP transmit scheduler top level: timer and transmit machines, APB registers.
// Depends on lts_pkg, lts_stream_if and lldp_transmit_scheduler_unit_macros.svh.
//
//  channel  dir   handshake            payload
//  req      in    req.valid/req.ready  req_item_t: tick mode, link, admin, requests
//  rsp      out   rsp.valid/rsp.ready  rsp_item_t: frame kind/TTL, phases, credit
//  apb      in    psel/penable/pready  register writes and reads, pready tied high
//
// Input register, then the settled state of both machines and the result are
// registered together. One request per cycle is sustained while rsp is ready;
// the state update of one request feeds the next through the state registers.
// A stalled rsp holds its result while one more request waits in the input
// register. Reset clears state to the initialize phases and config to defaults.
`include "lldp_transmit_scheduler_unit_macros.svh"

module lldp_transmit_scheduler_unit import lts_pkg::*; #(
    parameter int MAX_TRANSITIONS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lts_req_if.sink               req,
    lts_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Budget of repeated expiries left after the first timer action
    localparam int BUDGET_W = $clog2(MAX_TRANSITIONS + 1);
    localparam int CMP_W    = (BUDGET_W > COUNT_W) ? BUDGET_W : COUNT_W;
    localparam logic [BUDGET_W-1:0] BUDGET_FROM_IDLE = BUDGET_W'(MAX_TRANSITIONS - 1);
    localparam logic [BUDGET_W-1:0] BUDGET_FROM_INIT = BUDGET_W'(MAX_TRANSITIONS - 2);
    // Shutdown wait -> initialize -> idle -> info needs three transitions
    localparam logic THIRD_STEP_OK = (MAX_TRANSITIONS >= 3);

    typedef enum logic [1:0] {
        TXP_INIT = 2'd0,
        TXP_IDLE = 2'd1,
        TXP_SHUT = 2'd2
    } tx_phase_t;

    typedef enum logic {
        TMP_INIT = 1'b0,
        TMP_IDLE = 1'b1
    } timer_phase_t;

    // Configuration registers
    logic [INTERVAL_W-1:0] msg_tx_interval_reg;
    logic [HOLD_W-1:0]     msg_tx_hold_reg;
    logic [INTERVAL_W-1:0] msg_fast_tx_reg;
    logic [COUNT_W-1:0]    tx_fast_init_reg;
    logic [COUNT_W-1:0]    tx_credit_max_reg;
    logic [COUNT_W-1:0]    reinit_delay_reg;

    // Machine state
    tx_phase_t             tx_phase_reg, tx_phase_next;
    timer_phase_t          timer_phase_reg, timer_phase_next;
    logic [COUNT_W-1:0]    shutdown_wait_reg, shutdown_wait_next;
    logic [INTERVAL_W-1:0] refresh_timer_reg, refresh_timer_next;
    logic [COUNT_W-1:0]    fast_remaining_reg, fast_remaining_next;
    logic [COUNT_W-1:0]    credit_reg, credit_next;
    logic                  send_request_reg, send_request_next;
    logic                  change_latch_reg, change_latch_next;
    logic                  neighbor_latch_reg, neighbor_latch_next;
    logic [TTL_W-1:0]      advertised_ttl_reg, advertised_ttl_next;

    // Pipeline
    logic      in_valid_reg;
    req_item_t in_item_reg;
    logic      out_valid_reg;
    rsp_item_t out_item_reg, out_item_next;
    logic      advance;
    logic      cfg_write;
    logic [CFG_IDX_W-1:0] cfg_idx;

    // Combinational working values
    logic                  tx_on;
    logic                  mac_up;
    logic [COUNT_W-1:0]    wait_tick;
    logic [COUNT_W-1:0]    credit_tick;
    logic [INTERVAL_W-1:0] refresh_tick;
    logic                  neighbor_set;
    logic                  change_set;
    logic [PROD_W-1:0]     ttl_prod;
    logic [TTL_W-1:0]      ttl_calc;
    logic                  timer_act;
    logic [COUNT_W-1:0]    fast_seed;
    logic [COUNT_W-1:0]    fast_first;
    logic [BUDGET_W-1:0]   budget;
    logic [CMP_W-1:0]      fast_first_w;
    logic [CMP_W-1:0]      budget_w;
    logic [COUNT_W-1:0]    fast_settled;
    logic [1:0]            frame_kind_next;
    logic [TTL_W-1:0]      frame_ttl_next;
    logic                  reenter;

    //------------------------------------------------------------------
    // Handshakes
    //------------------------------------------------------------------
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_item_reg;

    //------------------------------------------------------------------
    // APB register port
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_tx_interval_reg <= RST_MSG_TX_INTERVAL;
            msg_tx_hold_reg     <= RST_MSG_TX_HOLD;
            msg_fast_tx_reg     <= RST_MSG_FAST_TX;
            tx_fast_init_reg    <= RST_TX_FAST_INIT;
            tx_credit_max_reg   <= RST_TX_CREDIT_MAX;
            reinit_delay_reg    <= RST_REINIT_DELAY;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MSG_TX_INTERVAL: msg_tx_interval_reg <= pwdata[INTERVAL_W-1:0];
                REG_MSG_TX_HOLD:     msg_tx_hold_reg     <= pwdata[HOLD_W-1:0];
                REG_MSG_FAST_TX:     msg_fast_tx_reg     <= pwdata[INTERVAL_W-1:0];
                REG_TX_FAST_INIT:    tx_fast_init_reg    <= pwdata[COUNT_W-1:0];
                REG_TX_CREDIT_MAX:   tx_credit_max_reg   <= pwdata[COUNT_W-1:0];
                REG_REINIT_DELAY:    reinit_delay_reg    <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (cfg_idx)
            REG_MSG_TX_INTERVAL: prdata = CFG_DATA_W'(msg_tx_interval_reg);
            REG_MSG_TX_HOLD:     prdata = CFG_DATA_W'(msg_tx_hold_reg);
            REG_MSG_FAST_TX:     prdata = CFG_DATA_W'(msg_fast_tx_reg);
            REG_TX_FAST_INIT:    prdata = CFG_DATA_W'(tx_fast_init_reg);
            REG_TX_CREDIT_MAX:   prdata = CFG_DATA_W'(tx_credit_max_reg);
            REG_REINIT_DELAY:    prdata = CFG_DATA_W'(reinit_delay_reg);
            default:             prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Tick, request latches and TTL
    //------------------------------------------------------------------
    assign mac_up = in_item_reg.mac_operational;
    assign tx_on  = (in_item_reg.admin_status == ADMIN_TX_ONLY) ||
                    (in_item_reg.admin_status == ADMIN_RX_TX);

    assign wait_tick    = (in_item_reg.mode && shutdown_wait_reg != '0) ?
                          shutdown_wait_reg - COUNT_W'(1) : shutdown_wait_reg;
    assign credit_tick  = (in_item_reg.mode && credit_reg < tx_credit_max_reg) ?
                          credit_reg + COUNT_W'(1) : credit_reg;
    assign refresh_tick = (in_item_reg.mode && refresh_timer_reg != '0) ?
                          refresh_timer_reg - INTERVAL_W'(1) : refresh_timer_reg;
    assign neighbor_set = neighbor_latch_reg || in_item_reg.new_neighbor;
    assign change_set   = change_latch_reg || in_item_reg.local_change;

    // interval * hold + 1, saturated
    assign ttl_prod = PROD_W'(msg_tx_interval_reg) * PROD_W'(msg_tx_hold_reg) + PROD_W'(1);
    assign ttl_calc = (ttl_prod > PROD_W'(TTL_MAX)) ? TTL_MAX : ttl_prod[TTL_W-1:0];

    //------------------------------------------------------------------
    // Timer machine, settled in one pass
    //------------------------------------------------------------------
    // After the first action, a zero reload keeps expiring: with a zero fast
    // interval each extra expiry eats one fast frame until the budget runs out.
    always_comb
    begin
        timer_phase_next    = timer_phase_reg;
        send_request_next   = send_request_reg;
        change_latch_next   = change_set;
        neighbor_latch_next = neighbor_set;
        refresh_timer_next  = refresh_tick;
        fast_remaining_next = fast_remaining_reg;
        credit_next         = credit_tick;
        timer_act           = 1'b0;
        fast_seed           = fast_remaining_reg;
        fast_first          = fast_remaining_reg;
        budget              = BUDGET_FROM_IDLE;
        fast_first_w        = '0;
        budget_w            = '0;
        fast_settled        = fast_remaining_reg;

        if (!mac_up || !tx_on)
        begin
            if (timer_phase_reg != TMP_INIT)
            begin
                timer_phase_next    = TMP_INIT;
                send_request_next   = 1'b0;
                change_latch_next   = 1'b0;
                neighbor_latch_next = 1'b0;
                refresh_timer_next  = '0;
                fast_remaining_next = '0;
                credit_next         = tx_credit_max_reg;
            end
        end
        else
        begin
            timer_phase_next = TMP_IDLE;
            budget = (timer_phase_reg == TMP_INIT) ? BUDGET_FROM_INIT : BUDGET_FROM_IDLE;

            // First action in idle, by priority
            if (neighbor_set)
            begin
                fast_seed  = (fast_remaining_reg == '0) ? tx_fast_init_reg
                                                         : fast_remaining_reg;
                fast_first = (fast_seed != '0) ? fast_seed - COUNT_W'(1) : fast_seed;
                timer_act  = 1'b1;
            end
            else if (refresh_tick == '0)
            begin
                fast_first = (fast_remaining_reg != '0) ?
                             fast_remaining_reg - COUNT_W'(1) : fast_remaining_reg;
                timer_act  = 1'b1;
            end
            else if (change_set)
            begin
                fast_first = fast_remaining_reg;
                timer_act  = 1'b1;
            end

            // Repeated expiries on a zero reload
            fast_first_w = CMP_W'(fast_first);
            budget_w     = CMP_W'(budget);
            if (msg_fast_tx_reg == '0)
            begin
                fast_settled = (fast_first_w > budget_w) ?
                               COUNT_W'(fast_first_w - budget_w) : '0;
            end
            else
            begin
                fast_settled = fast_first;
            end

            if (timer_act)
            begin
                neighbor_latch_next = 1'b0;
                change_latch_next   = 1'b0;
                send_request_next   = 1'b1;
                fast_remaining_next = fast_settled;
                refresh_timer_next  = (fast_settled != '0) ? msg_fast_tx_reg
                                                            : msg_tx_interval_reg;
            end
        end
    end

    //------------------------------------------------------------------
    // Transmit machine, after the timer machine
    //------------------------------------------------------------------
    assign reenter = (tx_phase_reg == TXP_SHUT && wait_tick == '0) ||
                     (tx_phase_reg != TXP_INIT && tx_phase_reg != TXP_IDLE &&
                      tx_phase_reg != TXP_SHUT);

    always_comb
    begin
        tx_phase_next       = tx_phase_reg;
        shutdown_wait_next  = wait_tick;
        advertised_ttl_next = advertised_ttl_reg;
        frame_kind_next     = FRAME_NONE;
        frame_ttl_next      = '0;
        out_item_next.credit_left = credit_next;

        if (!mac_up)
        begin
            if (tx_phase_reg != TXP_INIT)
            begin
                tx_phase_next      = TXP_INIT;
                shutdown_wait_next = '0;
            end
        end
        else
        begin
            unique case (tx_phase_reg)
                TXP_INIT:
                begin
                    if (tx_on)
                    begin
                        tx_phase_next       = TXP_IDLE;
                        advertised_ttl_next = ttl_calc;
                        if (send_request_next && credit_next != '0)
                        begin
                            frame_kind_next = FRAME_INFO;
                            frame_ttl_next  = ttl_calc;
                            out_item_next.credit_left = credit_next - COUNT_W'(1);
                        end
                    end
                end
                TXP_IDLE:
                begin
                    if (!tx_on)
                    begin
                        // shutdown beats a pending info frame
                        frame_kind_next    = FRAME_SHUTDOWN;
                        tx_phase_next      = TXP_SHUT;
                        shutdown_wait_next = reinit_delay_reg;
                        if (reinit_delay_reg == '0)
                        begin
                            tx_phase_next = TXP_INIT;
                        end
                    end
                    else if (send_request_next && credit_next != '0)
                    begin
                        frame_kind_next     = FRAME_INFO;
                        frame_ttl_next      = advertised_ttl_reg;
                        advertised_ttl_next = ttl_calc;
                        out_item_next.credit_left = credit_next - COUNT_W'(1);
                    end
                end
                default:
                begin
                    // shutdown wait done, or an unused code: back to initialize
                    if (reenter)
                    begin
                        tx_phase_next      = TXP_INIT;
                        shutdown_wait_next = '0;
                        if (tx_on)
                        begin
                            tx_phase_next       = TXP_IDLE;
                            advertised_ttl_next = ttl_calc;
                            if (THIRD_STEP_OK && send_request_next && credit_next != '0)
                            begin
                                frame_kind_next = FRAME_INFO;
                                frame_ttl_next  = ttl_calc;
                                out_item_next.credit_left = credit_next - COUNT_W'(1);
                            end
                        end
                    end
                end
            endcase
        end

        out_item_next.frame_kind  = frame_kind_next;
        out_item_next.frame_ttl   = frame_ttl_next;
        out_item_next.tx_phase    = tx_phase_next;
        out_item_next.timer_phase = timer_phase_next;
    end

    //------------------------------------------------------------------
    // State and valid flags
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            tx_phase_reg       <= TXP_INIT;
            timer_phase_reg    <= TMP_INIT;
            shutdown_wait_reg  <= '0;
            refresh_timer_reg  <= '0;
            fast_remaining_reg <= '0;
            credit_reg         <= RST_TX_CREDIT_MAX;
            send_request_reg   <= 1'b0;
            change_latch_reg   <= 1'b0;
            neighbor_latch_reg <= 1'b0;
            advertised_ttl_reg <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                tx_phase_reg       <= tx_phase_next;
                timer_phase_reg    <= timer_phase_next;
                shutdown_wait_reg  <= shutdown_wait_next;
                refresh_timer_reg  <= refresh_timer_next;
                fast_remaining_reg <= fast_remaining_next;
                credit_reg         <= out_item_next.credit_left;
                send_request_reg   <= (frame_kind_next == FRAME_INFO) ? 1'b0
                                                                      : send_request_next;
                change_latch_reg   <= change_latch_next;
                neighbor_latch_reg <= neighbor_latch_next;
                advertised_ttl_reg <= advertised_ttl_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg <= req.payload;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    `LTS_ASSERT_IMPLY(a_info_in_idle, out_valid_reg && out_item_reg.frame_kind == FRAME_INFO, out_item_reg.tx_phase == TX_CODE_IDLE, "info frame reported outside idle")
    `LTS_ASSERT_IMPLY(a_shutdown_ttl, out_valid_reg && out_item_reg.frame_kind == FRAME_SHUTDOWN, out_item_reg.frame_ttl == '0 && out_item_reg.tx_phase != TX_CODE_IDLE && out_item_reg.timer_phase == TMR_CODE_INIT, "bad shutdown frame result")
    `LTS_ASSERT_IMPLY(a_timer_init_quiet, timer_phase_reg == TMP_INIT, !send_request_reg, "send request pending in timer initialize")
    `LTS_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg, "result lost after advance")

endmodule

@@ sim/lts_scheduler_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the LLDP transmit scheduler: mirrors the timer and transmit machines.
// Depends on lts_pkg and the lts_req_if / lts_rsp_if channel interfaces.
module lts_scheduler_checker import lts_pkg::*; #(
    parameter int MAX_TRANSITIONS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lts_req_if                    req,
    lts_rsp_if                    rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    fail_count,
    output int                    reports_due
);

    localparam logic TMR_CODE_IDLE = 1'b1;
    localparam int   REPORT_LIMIT  = 10;

    // Shadow of the configuration registers
    logic [INTERVAL_W-1:0] cfg_interval;
    logic [HOLD_W-1:0]     cfg_hold;
    logic [INTERVAL_W-1:0] cfg_fast;
    logic [COUNT_W-1:0]    cfg_fast_init;
    logic [COUNT_W-1:0]    cfg_credit_max;
    logic [COUNT_W-1:0]    cfg_reinit;

    // Shadow of the machine state
    logic [1:0]            tx_state;
    logic                  timer_state;
    logic [COUNT_W-1:0]    wait_left;
    logic [INTERVAL_W-1:0] refresh_left;
    logic [COUNT_W-1:0]    fast_left;
    logic [COUNT_W-1:0]    credit;
    logic                  send_pending;
    logic                  change_pend;
    logic                  neighbor_pend;
    logic [TTL_W-1:0]      ttl_adv;

    rsp_item_t frames_due[$];
    int        mismatches;

    // Apply one event to the shadow state and work out the frame report it gives
    task automatic advance_lldp_tx(input req_item_t ev, output rsp_item_t res);
        logic              link_up;
        logic              tx_on;
        logic              moved;
        logic              kick_expire;
        logic              kick_signal;
        logic              go_idle;
        logic [PROD_W-1:0] ttl_calc;
        link_up = ev.mac_operational;
        tx_on   = (ev.admin_status == ADMIN_TX_ONLY) || (ev.admin_status == ADMIN_RX_TX);
        res     = '0;
        res.frame_kind = FRAME_NONE;

        // one-second tick
        if (ev.mode) begin
            if (wait_left != 0) wait_left = wait_left - 1'b1;
            if (credit < cfg_credit_max) credit = credit + 1'b1;
            if (refresh_left != 0) refresh_left = refresh_left - 1'b1;
        end
        if (ev.new_neighbor) neighbor_pend = 1'b1;
        if (ev.local_change) change_pend = 1'b1;

        // timer machine runs to a stable state first
        moved = 1'b1;
        for (int n = 0; n < MAX_TRANSITIONS && moved; n++) begin
            kick_expire = 1'b0;
            kick_signal = 1'b0;
            if (!link_up || !tx_on) begin
                if (timer_state != TMR_CODE_INIT) begin
                    send_pending  = 1'b0;
                    change_pend   = 1'b0;
                    refresh_left  = '0;
                    fast_left     = '0;
                    neighbor_pend = 1'b0;
                    credit        = cfg_credit_max;
                    timer_state   = TMR_CODE_INIT;
                end else begin
                    moved = 1'b0;
                end
            end else if (timer_state != TMR_CODE_IDLE) begin
                timer_state = TMR_CODE_IDLE;
            end else if (neighbor_pend) begin
                neighbor_pend = 1'b0;
                if (fast_left == 0) fast_left = cfg_fast_init;
                kick_expire = 1'b1;
            end else if (refresh_left == 0) begin
                kick_expire = 1'b1;
            end else if (change_pend) begin
                kick_signal = 1'b1;
            end else begin
                moved = 1'b0;
            end
            if (kick_expire && fast_left != 0) fast_left = fast_left - 1'b1;
            if (kick_expire || kick_signal) begin
                send_pending = 1'b1;
                change_pend  = 1'b0;
                refresh_left = (fast_left != 0) ? cfg_fast : cfg_interval;
                timer_state  = TMR_CODE_IDLE;
            end
        end

        // transmit machine; shutdown wins over a pending info frame
        moved = 1'b1;
        for (int n = 0; n < MAX_TRANSITIONS && moved; n++) begin
            go_idle = 1'b0;
            if (!link_up) begin
                if (tx_state != TX_CODE_INIT) begin
                    wait_left = '0;
                    tx_state  = TX_CODE_INIT;
                end else begin
                    moved = 1'b0;
                end
            end else begin
                case (tx_state)
                    TX_CODE_INIT:
                    begin
                        if (tx_on) go_idle = 1'b1;
                        else moved = 1'b0;
                    end
                    TX_CODE_IDLE:
                    begin
                        if (!tx_on) begin
                            res.frame_kind = FRAME_SHUTDOWN;
                            res.frame_ttl  = '0;
                            wait_left      = cfg_reinit;
                            tx_state       = TX_CODE_SHUT;
                        end else if (send_pending && credit != 0) begin
                            res.frame_kind = FRAME_INFO;
                            res.frame_ttl  = ttl_adv;
                            credit         = credit - 1'b1;
                            send_pending   = 1'b0;
                            go_idle        = 1'b1;
                        end else begin
                            moved = 1'b0;
                        end
                    end
                    TX_CODE_SHUT:
                    begin
                        if (wait_left == 0) tx_state = TX_CODE_INIT;
                        else moved = 1'b0;
                    end
                    default:
                    begin
                        wait_left = '0;
                        tx_state  = TX_CODE_INIT;
                    end
                endcase
            end
            // entering idle, or sending an info frame, refreshes the advertised TTL, saturated
            if (go_idle) begin
                ttl_calc = cfg_interval * cfg_hold + 1'b1;
                ttl_adv  = (ttl_calc > TTL_MAX) ? TTL_MAX : ttl_calc[TTL_W-1:0];
                tx_state = TX_CODE_IDLE;
            end
        end

        res.tx_phase    = tx_state;
        res.timer_phase = timer_state;
        res.credit_left = credit;
    endtask

    // Watch config writes, compare results, predict from accepted requests
    always @(posedge clk or negedge rst_n)
    begin : track
        rsp_item_t want;
        rsp_item_t got;
        if (!rst_n) begin
            cfg_interval   = RST_MSG_TX_INTERVAL;
            cfg_hold       = RST_MSG_TX_HOLD;
            cfg_fast       = RST_MSG_FAST_TX;
            cfg_fast_init  = RST_TX_FAST_INIT;
            cfg_credit_max = RST_TX_CREDIT_MAX;
            cfg_reinit     = RST_REINIT_DELAY;
            tx_state       = TX_CODE_INIT;
            timer_state    = TMR_CODE_INIT;
            wait_left      = '0;
            refresh_left   = '0;
            fast_left      = '0;
            credit         = RST_TX_CREDIT_MAX;
            send_pending   = 1'b0;
            change_pend    = 1'b0;
            neighbor_pend  = 1'b0;
            ttl_adv        = '0;
            mismatches     = 0;
            frames_due.delete();
            fail_count  <= 0;
            reports_due <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_MSG_TX_INTERVAL: cfg_interval   = pwdata[INTERVAL_W-1:0];
                    REG_MSG_TX_HOLD:     cfg_hold       = pwdata[HOLD_W-1:0];
                    REG_MSG_FAST_TX:     cfg_fast       = pwdata[INTERVAL_W-1:0];
                    REG_TX_FAST_INIT:    cfg_fast_init  = pwdata[COUNT_W-1:0];
                    REG_TX_CREDIT_MAX:   cfg_credit_max = pwdata[COUNT_W-1:0];
                    REG_REINIT_DELAY:    cfg_reinit     = pwdata[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (rsp.valid && rsp.ready) begin
                got = rsp.payload;
                if (frames_due.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("%0t: unexpected frame report", $time);
                        $display("    got kind %0d ttl %0d tx %0d timer %0d credit %0d",
                                 got.frame_kind, got.frame_ttl, got.tx_phase,
                                 got.timer_phase, got.credit_left);
                    end
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    if (got.frame_kind !== want.frame_kind || got.frame_ttl !== want.frame_ttl ||
                        got.tx_phase !== want.tx_phase || got.timer_phase !== want.timer_phase ||
                        got.credit_left !== want.credit_left) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("%0t: frame report mismatch", $time);
                            $display("  expected kind %0d ttl %0d tx %0d timer %0d credit %0d",
                                     want.frame_kind, want.frame_ttl, want.tx_phase,
                                     want.timer_phase, want.credit_left);
                            $display("  got      kind %0d ttl %0d tx %0d timer %0d credit %0d",
                                     got.frame_kind, got.frame_ttl, got.tx_phase,
                                     got.timer_phase, got.credit_left);
                        end
                        mismatches++;
                    end
                end
            end

            if (req.valid && req.ready) begin
                advance_lldp_tx(req.payload, want);
                frames_due = {frames_due, want};
            end

            fail_count  <= mismatches;
            reports_due <= frames_due.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the LLDP transmit scheduler bench: clock, reset, events, config writes, verdict.
// Depends on lts_pkg, the channel interfaces, the scheduler RTL and lts_scheduler_checker.
module testbench;
    import lts_pkg::*;

    localparam int SETTLE_LIMIT    = 10;
    localparam int PHASES          = 6;
    localparam int PHASE_EVENTS    = 140;
    localparam int REG_COUNT       = 6;
    localparam int HOLD_OFF_CYCLES = 60;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    reports_due;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_req;

    // Register order and one value set per phase, extremes included
    logic [CFG_IDX_W-1:0] reg_order[REG_COUNT] = '{REG_MSG_TX_INTERVAL, REG_MSG_TX_HOLD,
                                                   REG_MSG_FAST_TX, REG_TX_FAST_INIT,
                                                   REG_TX_CREDIT_MAX, REG_REINIT_DELAY};
    int unsigned cfg_plan[PHASES][REG_COUNT] = '{
        '{3, 2, 1, 3, 2, 1},
        '{4095, 127, 4095, 15, 15, 15},
        '{1, 1, 1, 1, 1, 1},
        '{0, 0, 0, 0, 0, 0},
        '{10, 100, 2, 8, 10, 10},
        '{5, 3, 2, 4, 3, 2}
    };

    lts_req_if req_ch ();
    lts_rsp_if rsp_ch ();

    lldp_transmit_scheduler_unit #(
        .MAX_TRANSITIONS(SETTLE_LIMIT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lts_scheduler_checker #(
        .MAX_TRANSITIONS(SETTLE_LIMIT)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .reports_due (reports_due)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic req_item_t make_event(input logic tick, input logic link,
                                             input logic [1:0] admin, input logic nbr,
                                             input logic chg);
        req_item_t ev;
        ev.mode            = tick;
        ev.mac_operational = link;
        ev.admin_status    = admin;
        ev.new_neighbor    = nbr;
        ev.local_change    = chg;
        return ev;
    endfunction

    // Mostly a live link with tx enabled; some shutdown stretches; some pure noise
    function automatic req_item_t random_event();
        req_item_t   ev;
        int unsigned pick;
        pick               = $urandom_range(99);
        ev.mode            = $urandom_range(99) < 55;
        ev.mac_operational = 1'b1;
        ev.new_neighbor    = $urandom_range(99) < 8;
        ev.local_change    = $urandom_range(99) < 20;
        if (pick < 70) begin
            ev.admin_status = $urandom_range(1) ? ADMIN_RX_TX : ADMIN_TX_ONLY;
        end else if (pick < 82) begin
            ev.admin_status = $urandom_range(1) ? ADMIN_RX_ONLY : ADMIN_DISABLED;
            ev.mode         = $urandom_range(99) < 80;
        end else begin
            ev.mac_operational = 1'($urandom_range(1));
            ev.admin_status    = 2'($urandom_range(3));
            ev.new_neighbor    = 1'($urandom_range(1));
            ev.local_change    = 1'($urandom_range(1));
        end
        return ev;
    endfunction

    // Offer one request, with random gaps ahead of it, and wait until it is taken
    task automatic send_event(input req_item_t ev);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= ev;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Stop offering and wait for every predicted result to come back
    task automatic settle_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (reports_due != 0);
    endtask

    // APB setup then access; the caller drops psel once after a burst of writes
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Receiver: random stalls, or a long hold-off each time one is requested
    initial
    begin : receiver
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req != holds_served) begin
                stall_left   = HOLD_OFF_CYCLES;
                holds_served = hold_off_req;
            end
            if (stall_left != 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin : stimulus
        int sent;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 34;
        recv_idle_pct  = 52;
        hold_off_req   = 0;
        sent           = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bring-up, fast start, credit drain, shutdown and link loss
        send_event(make_event(1'b0, 1'b0, ADMIN_DISABLED, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b0, ADMIN_RX_TX, 1'b1, 1'b1));
        send_event(make_event(1'b0, 1'b1, ADMIN_RX_TX, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b1, ADMIN_TX_ONLY, 1'b0, 1'b1));
        send_event(make_event(1'b0, 1'b1, ADMIN_RX_TX, 1'b0, 1'b1));
        send_event(make_event(1'b0, 1'b1, ADMIN_RX_TX, 1'b0, 1'b1));
        send_event(make_event(1'b0, 1'b1, ADMIN_RX_TX, 1'b0, 1'b1));
        send_event(make_event(1'b0, 1'b1, ADMIN_RX_TX, 1'b0, 1'b1));
        send_event(make_event(1'b1, 1'b1, ADMIN_RX_TX, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, ADMIN_RX_TX, 1'b1, 1'b0));
        send_event(make_event(1'b1, 1'b1, ADMIN_RX_TX, 1'b0, 1'b0));
        // shutdown must win over the pending info frame
        send_event(make_event(1'b0, 1'b1, ADMIN_RX_ONLY, 1'b0, 1'b1));
        send_event(make_event(1'b1, 1'b1, ADMIN_RX_ONLY, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, ADMIN_DISABLED, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, ADMIN_DISABLED, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b1, ADMIN_TX_ONLY, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, ADMIN_TX_ONLY, 1'b1, 1'b1));
        send_event(make_event(1'b0, 1'b0, ADMIN_TX_ONLY, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, ADMIN_RX_TX, 1'b1, 1'b1));
        send_event(make_event(1'b1, 1'b0, ADMIN_DISABLED, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b1, ADMIN_RX_TX, 1'b0, 1'b0));

        // Random phases, each under its own register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_results();
            for (int r = 0; r < REG_COUNT; r++)
                write_register(reg_order[r], cfg_plan[ph][r]);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            for (int k = 0; k < PHASE_EVENTS; k++) begin
                // idle split: receiver-heavy, then sender-heavy, then none
                if (sent < 2 * PHASE_EVENTS) begin
                    send_idle_pct = 34;
                    recv_idle_pct = 52;
                end else if (sent < 4 * PHASE_EVENTS) begin
                    send_idle_pct = 52;
                    recv_idle_pct = 34;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if (ph == 2 && k == PHASE_EVENTS / 2)
                    settle_results();
                if (ph == 4 && k == 20)
                    hold_off_req++;
                send_event(random_event());
                sent++;
            end
        end

        settle_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && reports_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lts_pkg.sv
rtl/lts_stream_if.sv
rtl/lldp_transmit_scheduler_unit.sv
sim/lts_scheduler_checker.sv
sim/testbench.sv
